>>> src/mexp_pkg.sv
package mexp_pkg;

  localparam int MOD_W = 31;
  localparam int IN_W  = 32;
  localparam int STEPS_MAX = (IN_W > MOD_W) ? IN_W : MOD_W;
  localparam int CNT_W = $clog2(STEPS_MAX);

  // configuration register indexes
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  // control from the sequencer to the serial units
  typedef struct packed {
    logic load;
    logic step;
  } mexp_ctl_t;

endpackage

>>> src/modular_exponentiation.sv
// channel   ports                                       transaction
// input     start, busy, in_base[31:0]                  start & !busy
// result    out_valid, out_power_result[30:0]           out_valid, one cycle
// config    cfg_we, cfg_addr, cfg_wdata[30:0]           cfg_we, 0 modulus, 1 exponent
//
// Per item: a remainder pass, one step per input bit, and a setup step; then
// per exponent bit up to the highest set bit a check, 31 serial multiply steps
// and an update. Square and multiply run side by side on two units.
// Modulus 0 answers 0 in the cycle after start, with no pass. out_valid is not held.
// Reset is synchronous; registers read modulus 1, exponent 0. Result stays until the next.
module modular_exponentiation import mexp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  in_base,
  output logic             out_valid,
  output logic [MOD_W-1:0] out_power_result,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [MOD_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RED   = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_CHK   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0] modulus_r, modulus_nxt;
  logic [MOD_W-1:0] exponent_r, exponent_nxt;
  logic [MOD_W-1:0] e_r, e_nxt;
  logic [MOD_W-1:0] res_r, res_nxt;
  logic [MOD_W-1:0] p_r, p_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0] out_res_r, out_res_nxt;
  mexp_ctl_t        red_ctl, mul_ctl;
  logic [MOD_W-1:0] rem;
  logic [MOD_W-1:0] prod_res, prod_sq;
  logic             accept;

  assign accept = start && (st_r == ST_IDLE);

  mexp_reduce u_reduce (
    .clk     (clk),
    .ctl     (red_ctl),
    .base    (in_base),
    .modulus (modulus_r),
    .rem     (rem)
  );

  mexp_mulmod u_mul_res (
    .clk     (clk),
    .ctl     (mul_ctl),
    .mul_a   (res_r),
    .mul_b   (p_r),
    .modulus (modulus_r),
    .product (prod_res)
  );

  mexp_mulmod u_mul_sq (
    .clk     (clk),
    .ctl     (mul_ctl),
    .mul_a   (p_r),
    .mul_b   (p_r),
    .modulus (modulus_r),
    .product (prod_sq)
  );

  always_comb begin
    modulus_nxt  = modulus_r;
    exponent_nxt = exponent_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MODULUS:  modulus_nxt  = cfg_wdata;
        REG_EXPONENT: exponent_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    e_nxt         = e_r;
    res_nxt       = res_r;
    p_nxt         = p_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    red_ctl       = '0;
    mul_ctl       = '0;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (modulus_r == '0) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = '0;
          end else begin
            red_ctl.load = 1'b1;
            cnt_nxt      = '0;
            st_nxt       = ST_RED;
          end
        end
      end
      ST_RED: begin
        red_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(IN_W - 1)) begin
          st_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        p_nxt   = rem;
        res_nxt = MOD_W'(1);
        e_nxt   = exponent_r;
        st_nxt  = ST_CHK;
      end
      ST_CHK: begin
        if (e_r == '0) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          st_nxt        = ST_IDLE;
        end else begin
          mul_ctl.load = 1'b1;
          cnt_nxt      = '0;
          st_nxt       = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MOD_W - 1)) begin
          st_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (e_r[0]) begin
          res_nxt = prod_res;
        end
        p_nxt  = prod_sq;
        e_nxt  = {1'b0, e_r[MOD_W-1:1]};
        st_nxt = ST_CHK;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      modulus_r   <= MOD_W'(1);
      exponent_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      modulus_r   <= modulus_nxt;
      exponent_r  <= exponent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r       <= e_nxt;
    res_r     <= res_nxt;
    p_r       <= p_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy             = (st_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

  // result strobe only once the sequencer is back at rest
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (st_r == ST_IDLE))
    else $error("result strobe while sequencer active");

  // multiply pass only runs with exponent bits left
  a_mul_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MUL) |-> (e_r != '0))
    else $error("multiply pass with exhausted exponent");

  a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UPD) |-> ($past(st_r) == ST_MUL) && ($past(cnt_r) == CNT_W'(MOD_W - 1)))
    else $error("update without full multiply pass");

  a_red_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SETUP) |-> ($past(cnt_r) == CNT_W'(IN_W - 1)))
    else $error("remainder pass cut short");

endmodule

>>> src/mexp_reduce.sv
// Restoring remainder, one dividend bit per step, MSB first.
module mexp_reduce import mexp_pkg::*; (
  input  logic             clk,
  input  mexp_ctl_t        ctl,
  input  logic [IN_W-1:0]  base,
  input  logic [MOD_W-1:0] modulus,
  output logic [MOD_W-1:0] rem
);

  logic [IN_W-1:0]  sh_r, sh_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [MOD_W:0]   trial;

  always_comb begin
    trial   = {rem_r, sh_r[IN_W-1]};
    sh_nxt  = sh_r;
    rem_nxt = rem_r;
    if (ctl.load) begin
      sh_nxt  = base;
      rem_nxt = '0;
    end else if (ctl.step) begin
      sh_nxt = {sh_r[IN_W-2:0], 1'b0};
      if (trial >= {1'b0, modulus}) begin
        rem_nxt = MOD_W'(trial - {1'b0, modulus});
      end else begin
        rem_nxt = trial[MOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign rem = rem_r;

endmodule

>>> src/mexp_mulmod.sv
// Bit-serial modular multiply: acc = 2*acc + bit*a, reduced each step.
// With acc < m and a <= m the sum stays below 3m, so one of three candidates fits.
module mexp_mulmod import mexp_pkg::*; (
  input  logic             clk,
  input  mexp_ctl_t        ctl,
  input  logic [MOD_W-1:0] mul_a,
  input  logic [MOD_W-1:0] mul_b,
  input  logic [MOD_W-1:0] modulus,
  output logic [MOD_W-1:0] product
);

  logic [MOD_W-1:0] a_r, a_nxt;
  logic [MOD_W-1:0] b_r, b_nxt;
  logic [MOD_W-1:0] acc_r, acc_nxt;
  logic [MOD_W+1:0] sum;
  logic [MOD_W+1:0] m1;
  logic [MOD_W+1:0] m2;

  always_comb begin
    m1  = {2'b00, modulus};
    m2  = {1'b0, modulus, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (b_r[MOD_W-1] ? {2'b00, a_r} : '0);
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    if (ctl.load) begin
      a_nxt   = mul_a;
      b_nxt   = mul_b;
      acc_nxt = '0;
    end else if (ctl.step) begin
      b_nxt = {b_r[MOD_W-2:0], 1'b0};
      if (sum >= m2) begin
        acc_nxt = MOD_W'(sum - m2);
      end else if (sum >= m1) begin
        acc_nxt = MOD_W'(sum - m1);
      end else begin
        acc_nxt = sum[MOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign product = acc_r;

endmodule
